@@ design/lbap_pkg.sv @@
// Shared constants, types and codes for the LED bargraph animation player.
package lbap_pkg;

    // Frame memory geometry
    localparam int FRAME_DEPTH = 256;
    localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    // Pass counting
    localparam int MAX_REPEATS = 15;
    localparam int PASS_W      = 4;

    // Most results one request may cause
    localparam int RESULT_CAP  = 16;
    localparam int EMIT_W      = $clog2(RESULT_CAP);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [PASS_W-1:0] pass_t;
    typedef logic [EMIT_W-1:0] emit_cnt_t;

    // Request op codes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEADER,
        ST_FRAME
    } state_t;

endpackage

@@ design/led_bargraph_animation_player.sv @@
// LED bargraph animation player: frame memory and the frame sequencer.
//
//  channel   signals                                           direction
//  -------   -----------------------------------------------   ---------
//  request   start, busy, op, entry_index, entry_upper,        in
//            entry_lower, entry_delay, start_index,
//            repeat_count, interruptible, button_pressed
//  result    result_valid, frame_word, last, playing           out
//
// A request is taken when start is high and busy is low. Loads and ticks that
// only count down finish in the accept cycle. A tick that ends a delay reads
// the next entry, which ST_FRAME takes from the registered read port, and the
// result is registered; a start passes through ST_HEADER before ST_FRAME. Each
// further pass chained inside one request adds a header read and a frame read,
// all through the registered read of the frame memory. Reset clears the
// sequencer and the held frame; the frame memory keeps no reset and needs no
// clearing pass. Results are strobed for one cycle and are never held off.
module led_bargraph_animation_player
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  entry_upper,
    input  logic [7:0]  entry_lower,
    input  logic [15:0] entry_delay,
    input  logic [7:0]  start_index,
    input  logic [3:0]  repeat_count,
    input  logic        interruptible,
    input  logic        button_pressed,
    output logic        result_valid,
    output logic [15:0] frame_word,
    output logic        last,
    output logic        playing
);

    // Frame memory: upper in 31..24, lower in 23..16, delay in 15..0
    logic [31:0] frame_mem [lbap_pkg::FRAME_DEPTH];

    lbap_pkg::state_t    state_reg, state_next;
    logic [15:0]         held_frame_reg, held_frame_next;
    logic [7:0]          cursor_reg, cursor_next;
    logic [7:0]          anim_start_reg, anim_start_next;
    logic [15:0]         delay_left_reg, delay_left_next;
    lbap_pkg::pass_t     passes_left_reg, passes_left_next;
    logic                upper_en_reg, upper_en_next;
    logic                lower_en_reg, lower_en_next;
    logic                anim_on_reg, anim_on_next;
    logic                int_mode_reg, int_mode_next;
    lbap_pkg::emit_cnt_t emit_cnt_reg, emit_cnt_next;

    logic                result_valid_reg, result_valid_next;
    logic [15:0]         frame_word_reg, frame_word_next;
    logic                last_reg, last_next;
    logic                playing_reg, playing_next;

    // Memory ports
    logic                wr_en;
    lbap_pkg::addr_t     wr_addr;
    logic [31:0]         wr_data;
    logic [7:0]          rd_idx;
    logic                rd_oob;
    logic [31:0]         rd_data_reg;
    logic                rd_oob_reg;
    logic [31:0]         entry;

    lbap_pkg::pass_t     reps;
    lbap_pkg::pass_t     passes_dec;
    logic [15:0]         held_upd;
    logic                tick_expire;

    assign busy         = (state_reg != lbap_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign frame_word   = frame_word_reg;
    assign last         = last_reg;
    assign playing      = playing_reg;

    // Entries beyond the memory read as zero
    assign rd_oob = (32'(rd_idx) >= lbap_pkg::FRAME_DEPTH);
    assign entry  = rd_oob_reg ? 32'd0 : rd_data_reg;

    // Repeat count saturates at the limit
    assign reps = (32'(repeat_count) > lbap_pkg::MAX_REPEATS) ?
                  lbap_pkg::pass_t'(lbap_pkg::MAX_REPEATS) : lbap_pkg::pass_t'(repeat_count);

    assign passes_dec  = passes_left_reg - lbap_pkg::pass_t'(1);
    assign tick_expire = (int_mode_reg && button_pressed) || (delay_left_reg <= 16'd1);

    // Held frame with the enabled bytes of the current entry
    assign held_upd = {upper_en_reg ? entry[31:24] : held_frame_reg[15:8],
                       lower_en_reg ? entry[23:16] : held_frame_reg[7:0]};

    // Sequencer: next state, memory access and result
    always_comb
    begin
        state_next        = state_reg;
        held_frame_next   = held_frame_reg;
        cursor_next       = cursor_reg;
        anim_start_next   = anim_start_reg;
        delay_left_next   = delay_left_reg;
        passes_left_next  = passes_left_reg;
        upper_en_next     = upper_en_reg;
        lower_en_next     = lower_en_reg;
        anim_on_next      = anim_on_reg;
        int_mode_next     = int_mode_reg;
        emit_cnt_next     = emit_cnt_reg;
        result_valid_next = 1'b0;
        frame_word_next   = frame_word_reg;
        last_next         = last_reg;
        playing_next      = playing_reg;
        wr_en             = 1'b0;
        wr_addr           = lbap_pkg::addr_t'(entry_index);
        wr_data           = {entry_upper, entry_lower, entry_delay};
        rd_idx            = cursor_reg;

        case (state_reg)
            lbap_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        lbap_pkg::OP_LOAD:
                        begin
                            wr_en = (32'(entry_index) < lbap_pkg::FRAME_DEPTH);
                        end
                        lbap_pkg::OP_START:
                        begin
                            anim_start_next  = start_index;
                            int_mode_next    = interruptible;
                            passes_left_next = reps;
                            delay_left_next  = 16'd0;
                            emit_cnt_next    = '0;
                            if (reps == '0)
                            begin
                                anim_on_next = 1'b0;
                            end
                            else
                            begin
                                anim_on_next = 1'b1;
                                rd_idx       = start_index;
                                state_next   = lbap_pkg::ST_HEADER;
                            end
                        end
                        lbap_pkg::OP_TICK:
                        begin
                            if (anim_on_reg)
                            begin
                                if (tick_expire)
                                begin
                                    delay_left_next = 16'd0;
                                    cursor_next     = cursor_reg + 8'd1;
                                    rd_idx          = cursor_reg + 8'd1;
                                    emit_cnt_next   = '0;
                                    state_next      = lbap_pkg::ST_FRAME;
                                end
                                else
                                begin
                                    delay_left_next = delay_left_reg - 16'd1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // First entry of a pass: header or first frame
            lbap_pkg::ST_HEADER:
            begin
                if (entry[15:0] == 16'd0)
                begin
                    upper_en_next = (entry[31:24] != 8'd0);
                    lower_en_next = (entry[23:16] != 8'd0);
                    cursor_next   = anim_start_reg + 8'd1;
                end
                else
                begin
                    upper_en_next = 1'b1;
                    lower_en_next = 1'b1;
                    cursor_next   = anim_start_reg;
                end
                rd_idx     = cursor_next;
                state_next = lbap_pkg::ST_FRAME;
            end

            // Show a frame; a zero delay ends the pass
            lbap_pkg::ST_FRAME:
            begin
                held_frame_next   = held_upd;
                frame_word_next   = held_upd;
                result_valid_next = 1'b1;
                emit_cnt_next     = emit_cnt_reg + lbap_pkg::emit_cnt_t'(1);
                if (entry[15:0] != 16'd0)
                begin
                    delay_left_next = entry[15:0];
                    playing_next    = 1'b1;
                    last_next       = 1'b1;
                    state_next      = lbap_pkg::ST_IDLE;
                end
                else
                begin
                    passes_left_next = passes_dec;
                    if (passes_dec == '0)
                    begin
                        anim_on_next    = 1'b0;
                        delay_left_next = 16'd0;
                        playing_next    = 1'b0;
                        last_next       = 1'b1;
                        state_next      = lbap_pkg::ST_IDLE;
                    end
                    else if (emit_cnt_reg == lbap_pkg::emit_cnt_t'(lbap_pkg::RESULT_CAP - 1))
                    begin
                        // Result limit reached: play stops
                        anim_on_next    = 1'b0;
                        delay_left_next = 16'd0;
                        playing_next    = 1'b1;
                        last_next       = 1'b1;
                        state_next      = lbap_pkg::ST_IDLE;
                    end
                    else
                    begin
                        playing_next = 1'b1;
                        last_next    = 1'b0;
                        rd_idx       = anim_start_reg;
                        state_next   = lbap_pkg::ST_HEADER;
                    end
                end
            end

            default:
            begin
                state_next = lbap_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lbap_pkg::ST_IDLE;
            held_frame_reg   <= 16'd0;
            cursor_reg       <= 8'd0;
            anim_start_reg   <= 8'd0;
            delay_left_reg   <= 16'd0;
            passes_left_reg  <= '0;
            upper_en_reg     <= 1'b1;
            lower_en_reg     <= 1'b1;
            anim_on_reg      <= 1'b0;
            int_mode_reg     <= 1'b0;
            emit_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            held_frame_reg   <= held_frame_next;
            cursor_reg       <= cursor_next;
            anim_start_reg   <= anim_start_next;
            delay_left_reg   <= delay_left_next;
            passes_left_reg  <= passes_left_next;
            upper_en_reg     <= upper_en_next;
            lower_en_reg     <= lower_en_next;
            anim_on_reg      <= anim_on_next;
            int_mode_reg     <= int_mode_next;
            emit_cnt_reg     <= emit_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        frame_word_reg <= frame_word_next;
        last_reg       <= last_next;
        playing_reg    <= playing_next;
    end

    // Frame memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= frame_mem[lbap_pkg::addr_t'(rd_idx)];
        rd_oob_reg  <= rd_oob;
    end

endmodule
